/* rtl/core/event_watch_table_defines.svh */
// assertion macros for the event watch table
`ifndef EVENT_WATCH_TABLE_DEFINES_SVH
`define EVENT_WATCH_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define EWT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define EWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EWT_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define EWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/core/ewt_pkg.sv */
package ewt_pkg;

  localparam int INSTANCES = 16;
  localparam int WATCHES   = 32;

  localparam int INST_W    = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
  localparam int WATCH_W   = (WATCHES > 1) ? $clog2(WATCHES) : 1;
  localparam int CNT_W     = $clog2(WATCHES + 1);
  localparam int ADDR_W    = INST_W + WATCH_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam logic [2:0] ACT_CREATE  = 3'd0;
  localparam logic [2:0] ACT_ADD     = 3'd1;
  localparam logic [2:0] ACT_MODIFY  = 3'd2;
  localparam logic [2:0] ACT_DELETE  = 3'd3;
  localparam logic [2:0] ACT_DESTROY = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CREATE,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } ewt_state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  inst;
    logic [15:0] owner;
    logic [7:0]  key;
    logic [31:0] mask;
    logic [63:0] data;
  } ewt_req_t;

  typedef struct packed {
    logic [7:0]  key;
    logic [31:0] mask;
    logic [63:0] data;
  } ewt_watch_t;

  typedef struct packed {
    logic       status;
    logic [3:0] new_instance;
  } ewt_resp_t;

endpackage

/* rtl/core/ewt_mem.sv */
module ewt_mem import ewt_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  ewt_watch_t        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output ewt_watch_t        rdata
);

  ewt_watch_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/ewt_seq.sv */
`include "event_watch_table_defines.svh"

module ewt_seq import ewt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ewt_req_t          req_in,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output ewt_resp_t         resp,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output ewt_watch_t        mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr,
  input  ewt_watch_t        mem_rdata
);

  ewt_state_t          state, state_next;
  ewt_req_t            req, req_next;
  ewt_resp_t           resp_next;
  logic [INST_W-1:0]   scan_idx, scan_next;
  logic [CNT_W-1:0]    rd_pos, rd_pos_next;
  logic                cmp_valid, cmp_valid_next;
  logic [WATCH_W-1:0]  cmp_pos, cmp_pos_next;

  logic                in_use [INSTANCES];
  logic [CNT_W-1:0]    counts [INSTANCES];
  logic [15:0]         owner_ids [INSTANCES];

  logic [INST_W-1:0]   inst_idx;
  logic                inst_hit;
  logic [CNT_W-1:0]    cur_cnt;
  logic [CNT_W-1:0]    cmp_after;
  logic                key_hit;
  logic                flag_set, flag_clr, cnt_we;
  logic [INST_W-1:0]   cnt_idx;
  logic [CNT_W-1:0]    cnt_val;

  assign inst_idx  = INST_W'(req.inst);
  assign inst_hit  = (32'(req.inst) < INSTANCES) && in_use[inst_idx];
  assign cur_cnt   = counts[inst_idx];
  assign cmp_after = CNT_W'(CNT_W'(cmp_pos) + CNT_W'(1));
  assign key_hit   = (mem_rdata.key == req.key);

  always_comb begin
    state_next     = state;
    req_next       = req;
    resp_next      = resp;
    scan_next      = scan_idx;
    rd_pos_next    = rd_pos;
    cmp_valid_next = cmp_valid;
    cmp_pos_next   = cmp_pos;
    mem_we         = 1'b0;
    mem_waddr      = {inst_idx, cmp_pos};
    mem_wdata      = '{key: req.key, mask: req.mask, data: req.data};
    mem_re         = 1'b0;
    mem_raddr      = {inst_idx, rd_pos[WATCH_W-1:0]};
    flag_set       = 1'b0;
    flag_clr       = 1'b0;
    cnt_we         = 1'b0;
    cnt_idx        = inst_idx;
    cnt_val        = cur_cnt;
    idle           = (state == S_IDLE);
    res_valid      = (state == S_RESP);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next   = req_in;
          resp_next  = '{status: 1'b1, new_instance: 4'd0};
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (req.action == ACT_CREATE) begin
          scan_next  = '0;
          state_next = S_CREATE;
        end else if (req.action > ACT_DESTROY || !inst_hit) begin
          state_next = S_RESP;
        end else begin
          state_next = S_RESP;
          case (req.action) inside
            ACT_ADD: begin
              if (cur_cnt < CNT_W'(WATCHES)) begin
                mem_we           = 1'b1;
                mem_waddr        = {inst_idx, cur_cnt[WATCH_W-1:0]};
                cnt_we           = 1'b1;
                cnt_val          = CNT_W'(cur_cnt + CNT_W'(1));
                resp_next.status = 1'b0;
              end
            end
            ACT_MODIFY, ACT_DELETE: begin
              if (cur_cnt != '0) begin
                rd_pos_next    = '0;
                cmp_valid_next = 1'b0;
                state_next     = S_SEARCH;
              end
            end
            ACT_DESTROY: begin
              flag_clr         = 1'b1;
              resp_next.status = 1'b0;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_CREATE: begin
        cnt_idx = scan_idx;
        if (!in_use[scan_idx]) begin
          flag_set   = 1'b1;
          cnt_we     = 1'b1;
          cnt_val    = '0;
          resp_next  = '{status: 1'b0, new_instance: 4'(scan_idx)};
          state_next = S_RESP;
        end else if (scan_idx == INST_W'(INSTANCES - 1)) begin
          state_next = S_RESP;
        end else begin
          scan_next = INST_W'(scan_idx + INST_W'(1));
        end
      end
      S_SEARCH: begin
        if (cmp_valid && key_hit) begin
          if (req.action == ACT_MODIFY) begin
            mem_we           = 1'b1;
            resp_next.status = 1'b0;
            state_next       = S_RESP;
          end else begin
            rd_pos_next    = cmp_after;
            cmp_valid_next = 1'b0;
            state_next     = S_SHIFT;
          end
        end else if (cmp_valid && cmp_after == cur_cnt) begin
          state_next = S_RESP;
        end else if (rd_pos < cur_cnt) begin
          mem_re         = 1'b1;
          rd_pos_next    = CNT_W'(rd_pos + CNT_W'(1));
          cmp_pos_next   = rd_pos[WATCH_W-1:0];
          cmp_valid_next = 1'b1;
        end else begin
          cmp_valid_next = 1'b0;
        end
      end
      S_SHIFT: begin
        // pending read lands one slot lower
        mem_we    = cmp_valid;
        mem_wdata = mem_rdata;
        if (rd_pos < cur_cnt) begin
          mem_re         = 1'b1;
          cmp_pos_next   = WATCH_W'(rd_pos - CNT_W'(1));
          rd_pos_next    = CNT_W'(rd_pos + CNT_W'(1));
          cmp_valid_next = 1'b1;
        end else begin
          cnt_we           = 1'b1;
          cnt_val          = CNT_W'(cur_cnt - CNT_W'(1));
          cmp_valid_next   = 1'b0;
          resp_next.status = 1'b0;
          state_next       = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmp_valid <= 1'b0;
      rd_pos    <= '0;
      for (int i = 0; i < INSTANCES; i++) begin
        in_use[i] <= 1'b0;
        counts[i] <= '0;
      end
    end else begin
      state     <= state_next;
      cmp_valid <= cmp_valid_next;
      rd_pos    <= rd_pos_next;
      if (flag_set) begin
        in_use[scan_idx] <= 1'b1;
      end
      if (flag_clr) begin
        in_use[inst_idx] <= 1'b0;
      end
      if (cnt_we) begin
        counts[cnt_idx] <= cnt_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    req      <= req_next;
    resp     <= resp_next;
    scan_idx <= scan_next;
    cmp_pos  <= cmp_pos_next;
    if (flag_set) begin
      owner_ids[scan_idx] <= req.owner;
    end
  end

  `EWT_ASSERT_NOW(a_mem_port_clash, clk, rst, mem_we && mem_re, mem_waddr != mem_raddr, "watch memory read and write hit the same entry")
  `EWT_ASSERT_NOW(a_search_bound, clk, rst, state == S_SEARCH, rd_pos <= cur_cnt, "search read past the end of the watch list")
  `EWT_ASSERT_NOW(a_claim_ok, clk, rst, res_valid && resp.new_instance != 4'd0, !resp.status, "claimed index reported on a failed beat")
  `EWT_ASSERT_NEXT(a_start_leaves_idle, clk, rst, start && idle, state == S_DISPATCH, "accepted beat did not start dispatch")

endmodule

/* rtl/core/event_watch_table.sv */
// add, destroy and any failed check go straight to the response; create scans slots from 0
// for a free instance and fails if none of the INSTANCES slots is free
// modify rewrites the matching watch; delete removes it and shifts later watches down
// one beat at a time: in_ready stays low until the result has moved to the output register
// a finished result sits in the output register while the next beat runs
// rst (synchronous) frees all instances and clears watch counts; watch memory is not cleared
module event_watch_table import ewt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [3:0]  instance_req,
  input  logic [15:0] owner,
  input  logic [7:0]  watch_key,
  input  logic [31:0] event_mask,
  input  logic [63:0] user_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [3:0]  new_instance
);

  logic              start;
  logic              idle;
  logic              res_valid;
  logic              res_ready;
  ewt_resp_t         resp;
  ewt_req_t          req_in;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  ewt_watch_t        mem_wdata, mem_rdata;

  assign in_ready  = idle;
  assign start     = in_valid && in_ready;
  assign res_ready = !out_valid || out_ready;
  assign req_in    = '{action: action, inst: instance_req, owner: owner,
                       key: watch_key, mask: event_mask, data: user_data};

  ewt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_in    (req_in),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .resp      (resp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ewt_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status       <= resp.status;
      new_instance <= resp.new_instance;
    end
  end

endmodule
